### rtl/ichist_pkg.sv
// shared constants, types and helpers for the isovalue cell span histogram
// no dependencies; used by ichist_lane, ichist_merge and the top level
`timescale 1ns / 1ps

package ichist_pkg;

  localparam int DEF_BIN_COUNT   = 256;
  localparam int DEF_COUNT_WIDTH = 32;

  // bins are interleaved over the lanes: bin = row * LANES + lane
  localparam int LANES     = 8;
  localparam int LANE_W    = 3;
  localparam int CORNERS   = 8;
  localparam int VOXEL_W   = 8;
  localparam int OUT_W     = 32;
  // enough row bits for the largest supported bin count
  localparam int ROW_MAX_W = 9;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SETUP,
    S_SWEEP,
    S_RD,
    S_RDW,
    S_DRAIN,
    S_FIN
  } state_t;

  typedef logic [VOXEL_W-1:0] voxel_t;
  typedef logic [CORNERS-1:0][VOXEL_W-1:0] cell_t;

  // row update travelling from the sequencer to every lane
  typedef struct packed {
    logic                 valid;
    logic                 clear;
    logic [ROW_MAX_W-1:0] row;
  } upd_t;

  function automatic voxel_t cell_min(input cell_t c);
    voxel_t m;
    m = c[0];
    for (int i = 1; i < CORNERS; i++) begin
      if (c[i] < m) m = c[i];
    end
    return m;
  endfunction

  function automatic voxel_t cell_max(input cell_t c);
    voxel_t m;
    m = c[0];
    for (int i = 1; i < CORNERS; i++) begin
      if (c[i] > m) m = c[i];
    end
    return m;
  endfunction

endpackage

### rtl/ichist_lane.sv
// one histogram lane: a bank of bin counters with read-modify-write update
// depends on ichist_pkg
`timescale 1ns / 1ps

module ichist_lane #(
  parameter int BIN_COUNT   = ichist_pkg::DEF_BIN_COUNT,
  parameter int COUNT_WIDTH = ichist_pkg::DEF_COUNT_WIDTH,
  parameter int LANE_ID     = 0,
  localparam int ROWS  = (BIN_COUNT + ichist_pkg::LANES - 1) / ichist_pkg::LANES,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                          clk,
  input  logic [ROW_W-1:0]              rd_row,
  input  ichist_pkg::upd_t              upd,
  input  ichist_pkg::voxel_t            span_lo,
  input  ichist_pkg::voxel_t            span_hi,
  output logic [COUNT_WIDTH-1:0]        rd_data,
  output logic [COUNT_WIDTH-1:0]        cand
);

  localparam int LW    = ichist_pkg::LANE_W;
  localparam int VW    = ichist_pkg::VOXEL_W;
  localparam int BIN_W = ROW_W + LW;
  localparam int CMP_W = ((BIN_W > VW) ? BIN_W : VW) + 1;

  logic [COUNT_WIDTH-1:0] mem [ROWS];
  logic [ROW_W-1:0]       wr_row;
  logic [CMP_W-1:0]       bin;
  logic                   in_span;
  logic [COUNT_WIDTH-1:0] bumped;

  assign wr_row = upd.row[ROW_W-1:0];
  assign bin    = CMP_W'({wr_row, LW'(LANE_ID)});

  assign in_span = upd.valid && !upd.clear &&
                   (bin >= CMP_W'(span_lo)) && (bin <= CMP_W'(span_hi)) &&
                   (bin < CMP_W'(BIN_COUNT));

  // saturating increment
  assign bumped = (&rd_data) ? rd_data : rd_data + 1'b1;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_row];
    if (upd.valid && upd.clear) begin
      mem[wr_row] <= '0;
    end else if (in_span) begin
      mem[wr_row] <= bumped;
    end
  end

  // bin 0 never takes part in the peak
  always_ff @(posedge clk) begin
    cand <= (in_span && (bin != '0)) ? bumped : '0;
  end

endmodule

### rtl/ichist_merge.sv
// merging stage: registered max tree over the lane candidates and the peak register
// depends on ichist_pkg
`timescale 1ns / 1ps

module ichist_merge #(
  parameter int COUNT_WIDTH = ichist_pkg::DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   clear,
  input  logic [COUNT_WIDTH-1:0] cand [ichist_pkg::LANES],
  output logic [COUNT_WIDTH-1:0] peak,
  output logic                   busy
);

  localparam int L   = ichist_pkg::LANES;
  localparam int LVL = $clog2(L);

  logic [COUNT_WIDTH-1:0] node [1:L-1];
  logic [LVL-1:0]         vpipe;

  // heap layout: node i takes children 2i and 2i+1, leaves are the lane inputs
  for (genvar i = 1; i < L; i++) begin : g_node
    logic [COUNT_WIDTH-1:0] a;
    logic [COUNT_WIDTH-1:0] b;
    if (2 * i >= L) begin : g_leaf
      assign a = cand[2 * i - L];
      assign b = cand[2 * i + 1 - L];
    end else begin : g_inner
      assign a = node[2 * i];
      assign b = node[2 * i + 1];
    end
    always_ff @(posedge clk) begin
      node[i] <= (a > b) ? a : b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= LVL'({vpipe, in_valid});
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      peak <= '0;
    end else if (vpipe[LVL-1] && (node[1] > peak)) begin
      peak <= node[1];
    end
  end

  assign busy = in_valid || (|vpipe);

endmodule

### rtl/isovalue_cell_span_histogram.sv
// top level of the isovalue cell span histogram: sequencer, lanes and merge stage
// depends on ichist_pkg, ichist_lane and ichist_merge
`timescale 1ns / 1ps

// usage:
// one request channel (in_valid / in_stall) carries opcode, eight corners and a
// bin index; one result channel (out_valid / out_stall) returns bin_count,
// peak_count, cell_low and cell_high, exactly one result per request.
// bins are spread over 8 lanes, each lane holding every eighth bin in a small
// memory; an accumulate or clear request walks the memory rows, one row per
// cycle in all lanes.
// accumulate: a setup step, a sweep over each row of 8 bins touched by the
//   span, a drain while the last update passes the max tree into the peak,
//   and the result load.
// clear: a pass over all BIN_COUNT/8 rows (32 at 256 bins), drain, result load.
// read: memory read, lane select, result load.
// the next request is taken in the cycle after the current one has moved to the
// result register; a result waiting under out_stall blocks only the following
// result.
// reset: a clearing pass zeroes all rows with in_stall high; it returns no result.
module isovalue_cell_span_histogram #(
  parameter int BIN_COUNT   = ichist_pkg::DEF_BIN_COUNT,
  parameter int COUNT_WIDTH = ichist_pkg::DEF_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  corner0,
  input  logic [7:0]  corner1,
  input  logic [7:0]  corner2,
  input  logic [7:0]  corner3,
  input  logic [7:0]  corner4,
  input  logic [7:0]  corner5,
  input  logic [7:0]  corner6,
  input  logic [7:0]  corner7,
  input  logic [7:0]  bin_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] bin_count,
  output logic [31:0] peak_count,
  output logic [7:0]  cell_low,
  output logic [7:0]  cell_high
);

  localparam int L      = ichist_pkg::LANES;
  localparam int LW     = ichist_pkg::LANE_W;
  localparam int RMW    = ichist_pkg::ROW_MAX_W;
  localparam int VW     = ichist_pkg::VOXEL_W;
  localparam int OW     = ichist_pkg::OUT_W;
  localparam int ROWS   = (BIN_COUNT + L - 1) / L;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RC_W   = ((ROW_W > VW) ? ROW_W : VW) + 1;
  localparam int BC_W   = $clog2(BIN_COUNT + 1);
  localparam int CMP_W  = ((BC_W > VW) ? BC_W : VW) + 1;
  localparam int WIDE_W = COUNT_WIDTH + OW;

  function automatic logic [OW-1:0] clip_out(input logic [COUNT_WIDTH-1:0] v);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(v);
    return ((wide >> OW) != '0) ? '1 : wide[OW-1:0];
  endfunction

  ichist_pkg::state_t state, state_next;
  ichist_pkg::op_t    item_op;
  ichist_pkg::voxel_t item_lo;
  ichist_pkg::voxel_t item_hi;
  ichist_pkg::voxel_t item_idx;
  ichist_pkg::cell_t  corners;
  ichist_pkg::upd_t   upd, upd_next;

  logic [ROW_W-1:0]       row, row_next;
  logic [ROW_W-1:0]       last, last_next;
  logic                   emit, emit_next;
  logic [OW-1:0]          rd_value, rd_value_next;
  logic                   cand_valid;
  logic                   peak_clear;
  logic                   load_out;
  logic                   accept;
  logic [ROW_W-1:0]       rd_row;
  logic [RC_W-1:0]        lo_row;
  logic [RC_W-1:0]        hi_row;
  logic [RC_W-1:0]        rows_last;
  logic [COUNT_WIDTH-1:0] lane_rd   [L];
  logic [COUNT_WIDTH-1:0] lane_cand [L];
  logic [COUNT_WIDTH-1:0] peak;
  logic                   merge_busy;

  assign corners = {corner7, corner6, corner5, corner4,
                    corner3, corner2, corner1, corner0};

  assign in_stall  = (state != ichist_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign lo_row    = RC_W'(item_lo >> LW);
  assign hi_row    = RC_W'(item_hi >> LW);
  assign rows_last = RC_W'(ROWS - 1);

  always_comb begin
    state_next    = state;
    row_next      = row;
    last_next     = last;
    emit_next     = emit;
    rd_value_next = rd_value;
    upd_next      = '0;
    peak_clear    = 1'b0;
    load_out      = 1'b0;
    rd_row        = row;
    case (state)
      ichist_pkg::S_CLR: begin
        upd_next.valid = 1'b1;
        upd_next.clear = 1'b1;
        upd_next.row   = RMW'(row);
        if (row == ROW_W'(ROWS - 1)) begin
          state_next = ichist_pkg::S_DRAIN;
        end else begin
          row_next = row + 1'b1;
        end
      end
      ichist_pkg::S_IDLE: begin
        if (in_valid) begin
          emit_next     = 1'b1;
          rd_value_next = '0;
          case (ichist_pkg::op_t'(opcode))
            ichist_pkg::OP_CLEAR: begin
              peak_clear = 1'b1;
              row_next   = '0;
              state_next = ichist_pkg::S_CLR;
            end
            ichist_pkg::OP_ACCUM: state_next = ichist_pkg::S_SETUP;
            ichist_pkg::OP_READ:  state_next = ichist_pkg::S_RD;
            default:              state_next = ichist_pkg::S_FIN;
          endcase
        end
      end
      ichist_pkg::S_SETUP: begin
        // a span lying wholly above the last bin touches nothing
        if (lo_row > rows_last) begin
          state_next = ichist_pkg::S_DRAIN;
        end else begin
          row_next   = ROW_W'(lo_row);
          last_next  = ROW_W'((hi_row < rows_last) ? hi_row : rows_last);
          state_next = ichist_pkg::S_SWEEP;
        end
      end
      ichist_pkg::S_SWEEP: begin
        upd_next.valid = 1'b1;
        upd_next.row   = RMW'(row);
        if (row == last) begin
          state_next = ichist_pkg::S_DRAIN;
        end else begin
          row_next = row + 1'b1;
        end
      end
      ichist_pkg::S_RD: begin
        rd_row     = ROW_W'(RC_W'(item_idx >> LW));
        state_next = ichist_pkg::S_RDW;
      end
      ichist_pkg::S_RDW: begin
        if (CMP_W'(item_idx) < CMP_W'(BIN_COUNT)) begin
          rd_value_next = clip_out(lane_rd[item_idx[LW-1:0]]);
        end else begin
          rd_value_next = '0;
        end
        state_next = ichist_pkg::S_FIN;
      end
      ichist_pkg::S_DRAIN: begin
        if (!upd.valid && !merge_busy) begin
          state_next = emit ? ichist_pkg::S_FIN : ichist_pkg::S_IDLE;
        end
      end
      ichist_pkg::S_FIN: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ichist_pkg::S_IDLE;
        end
      end
      default: state_next = ichist_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ichist_pkg::S_CLR;
      row        <= '0;
      emit       <= 1'b0;
      upd        <= '0;
      cand_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      row        <= row_next;
      emit       <= emit_next;
      upd        <= upd_next;
      cand_valid <= upd.valid && !upd.clear;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    last     <= last_next;
    rd_value <= rd_value_next;
    if (accept) begin
      item_op  <= ichist_pkg::op_t'(opcode);
      item_lo  <= ichist_pkg::cell_min(corners);
      item_hi  <= ichist_pkg::cell_max(corners);
      item_idx <= bin_index;
    end
    if (load_out) begin
      bin_count  <= rd_value;
      peak_count <= clip_out(peak);
      cell_low   <= (item_op == ichist_pkg::OP_ACCUM) ? item_lo : '0;
      cell_high  <= (item_op == ichist_pkg::OP_ACCUM) ? item_hi : '0;
    end
  end

  for (genvar g = 0; g < L; g++) begin : g_lane
    ichist_lane #(
      .BIN_COUNT   (BIN_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH),
      .LANE_ID     (g)
    ) u_lane (
      .clk     (clk),
      .rd_row  (rd_row),
      .upd     (upd),
      .span_lo (item_lo),
      .span_hi (item_hi),
      .rd_data (lane_rd[g]),
      .cand    (lane_cand[g])
    );
  end

  ichist_merge #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cand_valid),
    .clear    (peak_clear),
    .cand     (lane_cand),
    .peak     (peak),
    .busy     (merge_busy)
  );

endmodule
